// File: hw/rtl/sliding_window_maximum_core_defines.svh
// Assertion macros shared by the sliding window maximum checker.
`ifndef SLIDING_WINDOW_MAXIMUM_CORE_DEFINES_SVH
`define SLIDING_WINDOW_MAXIMUM_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SWM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sliding window maximum: assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SWM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sliding window maximum: assertion failed");

`endif

// File: hw/rtl/swm_pkg.sv
// Shared constants, types and functions of the sliding window maximum core.
package swm_pkg;

    localparam int MAX_WINDOW  = 64;
    localparam int SAMPLE_BITS = 32;
    localparam int CFG_BITS    = 7;
    localparam int WIN_BITS    = $clog2(MAX_WINDOW + 1);
    localparam int CMP_BITS    = (CFG_BITS > WIN_BITS) ? CFG_BITS : WIN_BITS;
    localparam int LEVELS      = $clog2(MAX_WINDOW);
    localparam int TREE_N      = 1 << LEVELS;
    localparam int DATA_BITS   = ((SAMPLE_BITS + 7) / 8) * 8;

    localparam logic [CFG_BITS-1:0] WINDOW_RESET = CFG_BITS'(3);

    typedef struct packed {
        logic                          valid;
        logic signed [SAMPLE_BITS-1:0] value;
    } entry_t;

    function automatic entry_t pick_max(entry_t a, entry_t b);
        entry_t r;
        if (a.valid && (!b.valid || ($signed(a.value) >= $signed(b.value))))
        begin
            r = a;
        end
        else
        begin
            r = b;
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/swm_cell.sv
// One queue cell: takes its neighbor's entry on each sample and drops stale or beaten ones.
module swm_cell (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    load,
    input  logic                                    retire,
    input  logic signed [swm_pkg::SAMPLE_BITS-1:0]  sample,
    input  swm_pkg::entry_t                         src,
    output swm_pkg::entry_t                         q
);

    logic                                   valid_reg;
    logic                                   valid_next;
    logic signed [swm_pkg::SAMPLE_BITS-1:0] value_reg;

    always_comb
    begin
        valid_next = src.valid && !retire && !($signed(src.value) < sample);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            value_reg <= src.value;
        end
    end

    assign q.valid = valid_reg;
    assign q.value = value_reg;

endmodule

// File: hw/rtl/swm_tree.sv
// Registered max tree over the cell row, one level per stage, with its valid pipe.
module swm_tree (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            item_in,
    input  swm_pkg::entry_t leaf [swm_pkg::MAX_WINDOW],
    output logic            result_valid,
    output swm_pkg::entry_t root
);

    swm_pkg::entry_t            pad      [swm_pkg::TREE_N];
    swm_pkg::entry_t            tree_reg [1:swm_pkg::TREE_N-1];
    logic [swm_pkg::LEVELS:0]   stage_reg;

    for (genvar j = 0; j < swm_pkg::TREE_N; j++)
    begin : g_pad
        if (j < swm_pkg::MAX_WINDOW)
        begin : g_real
            assign pad[j] = leaf[j];
        end
        else
        begin : g_empty
            assign pad[j] = '0;
        end
    end

    for (genvar i = 1; i < swm_pkg::TREE_N; i++)
    begin : g_node
        swm_pkg::entry_t lo;
        swm_pkg::entry_t hi;

        if (2 * i >= swm_pkg::TREE_N)
        begin : g_from_leaf
            assign lo = pad[2 * i - swm_pkg::TREE_N];
            assign hi = pad[2 * i + 1 - swm_pkg::TREE_N];
        end
        else
        begin : g_from_node
            assign lo = tree_reg[2 * i];
            assign hi = tree_reg[2 * i + 1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                tree_reg[i] <= swm_pkg::pick_max(lo, hi);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else if (en)
        begin
            stage_reg <= {stage_reg[swm_pkg::LEVELS-1:0], item_in};
        end
    end

    assign result_valid = stage_reg[swm_pkg::LEVELS];
    assign root         = tree_reg[1];

endmodule

// File: hw/rtl/sliding_window_maximum_core.sv
// Top level of the sliding window maximum core: cell row, fill tracking and max tree.
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid / s_axis_tready  tdata[31:0] sample, tuser start_of_stream
//  m_axis    out        m_axis_tvalid / m_axis_tready  tdata[31:0] window_max
//  cfg       in         cfg_valid / cfg_ready          cfg_data[6:0] window_size
//
//  One sample per cycle while the output is not stalled; each sample is registered in
//  the cell row and its result then passes the one-level-per-stage max tree over it.
//  Reset clears all cell valid bits and the fill state; window_size returns to 3.
//  A stalled output freezes the whole pipe and drops s_axis_tready in that cycle.
//  cfg_ready is always high.
module sliding_window_maximum_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [swm_pkg::DATA_BITS-1:0]   s_axis_tdata,   // [31:0] sample
    input  logic                            s_axis_tuser,   // [0] start_of_stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [swm_pkg::DATA_BITS-1:0]   m_axis_tdata,   // [31:0] window_max
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [swm_pkg::CFG_BITS-1:0]    cfg_data
);

    logic                                   en;
    logic                                   accept;
    logic signed [swm_pkg::SAMPLE_BITS-1:0] sample;
    logic [swm_pkg::CFG_BITS-1:0]           window_size_reg;
    logic [swm_pkg::CMP_BITS-1:0]           size_ext;
    logic [swm_pkg::CMP_BITS-1:0]           eff_w;
    logic [swm_pkg::WIN_BITS-1:0]           fill_cnt_reg;
    logic [swm_pkg::WIN_BITS-1:0]           fill_cnt_next;
    logic [swm_pkg::WIN_BITS-1:0]           fill_base;
    logic                                   filled_reg;
    logic                                   filled_next;
    swm_pkg::entry_t                        head_src;
    swm_pkg::entry_t                        cell_q   [swm_pkg::MAX_WINDOW];
    logic [swm_pkg::MAX_WINDOW-1:0]         retire;
    logic                                   result_valid;
    swm_pkg::entry_t                        root;

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign accept        = s_axis_tvalid && en;
    assign sample        = $signed(s_axis_tdata[swm_pkg::SAMPLE_BITS-1:0]);
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= swm_pkg::WINDOW_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            window_size_reg <= cfg_data;
        end
    end

    // clamp window to 1..MAX_WINDOW
    always_comb
    begin
        size_ext = swm_pkg::CMP_BITS'(window_size_reg);
        if (size_ext == '0)
        begin
            eff_w = swm_pkg::CMP_BITS'(1);
        end
        else if (size_ext > swm_pkg::CMP_BITS'(swm_pkg::MAX_WINDOW))
        begin
            eff_w = swm_pkg::CMP_BITS'(swm_pkg::MAX_WINDOW);
        end
        else
        begin
            eff_w = size_ext;
        end
    end

    always_comb
    begin
        fill_base   = s_axis_tuser ? '0 : fill_cnt_reg;
        filled_next = (!s_axis_tuser && filled_reg)
                    || ((swm_pkg::CMP_BITS'(fill_base) + swm_pkg::CMP_BITS'(1)) >= eff_w);
        if (fill_base == swm_pkg::WIN_BITS'(swm_pkg::MAX_WINDOW))
        begin
            fill_cnt_next = fill_base;
        end
        else
        begin
            fill_cnt_next = fill_base + swm_pkg::WIN_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_cnt_reg <= '0;
            filled_reg   <= 1'b0;
        end
        else if (accept)
        begin
            fill_cnt_reg <= fill_cnt_next;
            filled_reg   <= filled_next;
        end
    end

    assign head_src.valid = 1'b1;
    assign head_src.value = sample;
    assign retire[0]      = 1'b0;

    swm_cell u_cell_head (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (accept),
        .retire (retire[0]),
        .sample (sample),
        .src    (head_src),
        .q      (cell_q[0])
    );

    for (genvar k = 1; k < swm_pkg::MAX_WINDOW; k++)
    begin : g_cell
        // drop entries reaching age k when the window no longer covers them, and all on start of stream
        assign retire[k] = s_axis_tuser || (swm_pkg::CMP_BITS'(k) >= eff_w);

        swm_cell u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .load   (accept),
            .retire (retire[k]),
            .sample (sample),
            .src    (cell_q[k-1]),
            .q      (cell_q[k])
        );
    end

    swm_tree u_tree (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .item_in      (accept && filled_next),
        .leaf         (cell_q),
        .result_valid (result_valid),
        .root         (root)
    );

    assign m_axis_tvalid = result_valid;
    assign m_axis_tdata  = swm_pkg::DATA_BITS'(unsigned'(root.value));

endmodule

// File: hw/rtl/swm_checker.sv
// Port-level checker for the sliding window maximum core, bound to the top level.
`include "sliding_window_maximum_core_defines.svh"

module swm_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [swm_pkg::DATA_BITS-1:0]   m_axis_tdata,
    input logic                            cfg_valid,
    input logic                            cfg_ready
);

    `SWM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    `SWM_ASSERT_NOW(a_in_ready, 1'b1, s_axis_tready == (!m_axis_tvalid || m_axis_tready))

    `SWM_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind sliding_window_maximum_core swm_checker u_swm_checker (.*);

// File: sim/sliding_window_maximum_core_tb.sv
// Testbench for the sliding window maximum core: directed table, random streams, deque predictor.
module sliding_window_maximum_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POS_WRAP    = 2 * swm_pkg::MAX_WINDOW;
    localparam int POS_BITS    = $clog2(POS_WRAP);
    localparam int SETTLE      = 2 * (swm_pkg::LEVELS + 1) + 4;
    localparam int CYCLE_LIMIT = 100000;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 46;

    typedef enum {ROW_SAMPLE, ROW_WINDOW} row_kind_t;
    typedef enum {CHK_MODEL, CHK_NONE, CHK_VALUE} row_check_t;
    typedef enum {FLOW_FREE, FLOW_TX_GAPS, FLOW_RX_STALLS, FLOW_BOTH} flow_t;

    typedef struct {
        row_kind_t                              kind;
        logic [swm_pkg::CFG_BITS-1:0]           win;
        logic signed [swm_pkg::SAMPLE_BITS-1:0] sample;
        logic                                   sos;
        row_check_t                             chk;
        logic signed [swm_pkg::SAMPLE_BITS-1:0] value;
    } stim_row_t;

    logic                                   clk;
    logic                                   rst_n;
    logic                                   s_axis_tvalid;
    logic                                   s_axis_tready;
    logic [swm_pkg::DATA_BITS-1:0]          s_axis_tdata;   // [31:0] sample
    logic                                   s_axis_tuser;   // [0] start_of_stream
    logic                                   m_axis_tvalid;
    logic                                   m_axis_tready;
    logic [swm_pkg::DATA_BITS-1:0]          m_axis_tdata;   // [31:0] window_max
    logic                                   cfg_valid;
    logic                                   cfg_ready;
    logic [swm_pkg::CFG_BITS-1:0]           cfg_data;

    stim_row_t plan [0:27] = '{
        '{ROW_SAMPLE, 7'd0,   32'sh7FFFFFFF, 1'b1, CHK_NONE,  32'sd0},
        '{ROW_SAMPLE, 7'd0,   32'sh80000000, 1'b0, CHK_NONE,  32'sd0},
        '{ROW_SAMPLE, 7'd0,   32'sd0,        1'b0, CHK_VALUE, 32'sh7FFFFFFF},
        '{ROW_SAMPLE, 7'd0,   32'sh80000000, 1'b0, CHK_VALUE, 32'sd0},
        '{ROW_SAMPLE, 7'd0,   -32'sd1,       1'b0, CHK_VALUE, 32'sd0},
        '{ROW_SAMPLE, 7'd0,   -32'sd1,       1'b0, CHK_VALUE, -32'sd1},
        '{ROW_SAMPLE, 7'd0,   32'sd100,      1'b1, CHK_NONE,  32'sd0},
        '{ROW_SAMPLE, 7'd0,   32'sd100,      1'b0, CHK_NONE,  32'sd0},
        '{ROW_SAMPLE, 7'd0,   32'sd100,      1'b0, CHK_VALUE, 32'sd100},
        '{ROW_SAMPLE, 7'd0,   32'sh80000000, 1'b0, CHK_VALUE, 32'sd100},
        '{ROW_SAMPLE, 7'd0,   32'sd50,       1'b0, CHK_MODEL, 32'sd0},
        '{ROW_SAMPLE, 7'd0,   32'sd40,       1'b0, CHK_MODEL, 32'sd0},
        '{ROW_SAMPLE, 7'd0,   32'sd30,       1'b0, CHK_MODEL, 32'sd0},
        '{ROW_SAMPLE, 7'd0,   32'sd31,       1'b0, CHK_MODEL, 32'sd0},
        '{ROW_SAMPLE, 7'd0,   32'sd60,       1'b0, CHK_MODEL, 32'sd0},
        '{ROW_WINDOW, 7'd0,   32'sd0,        1'b0, CHK_MODEL, 32'sd0},
        '{ROW_SAMPLE, 7'd0,   32'sd7,        1'b0, CHK_VALUE, 32'sd7},
        '{ROW_SAMPLE, 7'd0,   -32'sd9,       1'b0, CHK_VALUE, -32'sd9},
        '{ROW_WINDOW, 7'd127, 32'sd0,        1'b0, CHK_MODEL, 32'sd0},
        '{ROW_SAMPLE, 7'd0,   -32'sd20,      1'b0, CHK_MODEL, 32'sd0},
        '{ROW_SAMPLE, 7'd0,   -32'sd30,      1'b0, CHK_MODEL, 32'sd0},
        '{ROW_WINDOW, 7'd65,  32'sd0,        1'b0, CHK_MODEL, 32'sd0},
        '{ROW_SAMPLE, 7'd0,   32'sd5,        1'b1, CHK_NONE,  32'sd0},
        '{ROW_WINDOW, 7'd64,  32'sd0,        1'b0, CHK_MODEL, 32'sd0},
        '{ROW_SAMPLE, 7'd0,   32'sh7FFFFFFF, 1'b0, CHK_NONE,  32'sd0},
        '{ROW_WINDOW, 7'd1,   32'sd0,        1'b0, CHK_MODEL, 32'sd0},
        '{ROW_SAMPLE, 7'd0,   32'sh55555555, 1'b0, CHK_MODEL, 32'sd0},
        '{ROW_SAMPLE, 7'd0,   32'sh2AAAAAAA, 1'b1, CHK_VALUE, 32'sh2AAAAAAA}
    };

    int window_plan [8] = '{1, 64, 0, 127, 2, 65, 5, 3};

    logic signed [swm_pkg::SAMPLE_BITS-1:0] cand_val [swm_pkg::MAX_WINDOW];
    logic [POS_BITS-1:0]                    cand_pos [swm_pkg::MAX_WINDOW];
    int                                     dq_head;
    int                                     dq_count;
    int                                     stream_pos;
    bit                                     win_full;
    logic [swm_pkg::CFG_BITS-1:0]           win_len = swm_pkg::WINDOW_RESET;

    logic signed [swm_pkg::SAMPLE_BITS-1:0] max_due [$];
    flow_t                                  flow = FLOW_FREE;
    int                                     fails;
    int                                     cycles;

    sliding_window_maximum_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic bit roll(flow_t side);
        int pct;
        pct = (flow == side) ? 54 : ((flow == FLOW_BOTH) ? 7 : 0);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic logic signed [swm_pkg::SAMPLE_BITS-1:0] pick_sample(
        logic signed [swm_pkg::SAMPLE_BITS-1:0] prior);
        logic signed [swm_pkg::SAMPLE_BITS-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $signed($urandom_range(0, 16)) - 8;
            4, 5, 6:    v = $urandom;
            7, 8:       v = prior + $signed($urandom_range(0, 40)) - 20;
            default:    v = $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
        endcase
        return v;
    endfunction

    task automatic track_max(
        input  logic signed [swm_pkg::SAMPLE_BITS-1:0] x,
        input  logic                                   sos,
        output bit                                     emits,
        output logic signed [swm_pkg::SAMPLE_BITS-1:0] peak);
        int w;
        int p;
        int age;
        w = int'(win_len);
        if (w == 0)
        begin
            w = 1;
        end
        if (w > swm_pkg::MAX_WINDOW)
        begin
            w = swm_pkg::MAX_WINDOW;
        end
        if (sos)
        begin
            dq_head    = 0;
            dq_count   = 0;
            stream_pos = 0;
            win_full   = 1'b0;
        end
        p = stream_pos;
        // retire entries that have aged out of the window
        while (dq_count > 0)
        begin
            age = (p + POS_WRAP - int'(cand_pos[dq_head])) % POS_WRAP;
            if (age < w)
            begin
                break;
            end
            dq_head = (dq_head + 1) % swm_pkg::MAX_WINDOW;
            dq_count--;
        end
        // drop tail entries strictly smaller than the new sample
        while (dq_count > 0
               && cand_val[(dq_head + dq_count - 1) % swm_pkg::MAX_WINDOW] < x)
        begin
            dq_count--;
        end
        cand_val[(dq_head + dq_count) % swm_pkg::MAX_WINDOW] = x;
        cand_pos[(dq_head + dq_count) % swm_pkg::MAX_WINDOW] = POS_BITS'(p);
        dq_count++;
        if (!win_full && p + 1 >= w)
        begin
            win_full = 1'b1;
        end
        stream_pos = (p + 1) % POS_WRAP;
        emits = win_full;
        peak  = cand_val[dq_head];
    endtask

    task automatic send_sample(
        input logic signed [swm_pkg::SAMPLE_BITS-1:0] x,
        input logic                                   sos,
        input row_check_t                             chk,
        input logic signed [swm_pkg::SAMPLE_BITS-1:0] typed);
        bit                                     emits;
        logic signed [swm_pkg::SAMPLE_BITS-1:0] peak;
        while (roll(FLOW_TX_GAPS))
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= x;
        s_axis_tuser  <= sos;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        track_max(x, sos, emits, peak);
        if (chk == CHK_VALUE)
        begin
            max_due = {max_due, typed};
        end
        else if (chk == CHK_MODEL && emits)
        begin
            max_due = {max_due, peak};
        end
    endtask

    task automatic write_window(input logic [swm_pkg::CFG_BITS-1:0] w);
        flow_t saved;
        saved = flow;
        s_axis_tvalid <= 1'b0;
        while (max_due.size() != 0)
        begin
            @(posedge clk);
        end
        // let requests that produce no result leave the pipe
        flow = FLOW_FREE;
        repeat (SETTLE) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= w;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        win_len = w;
        flow = saved;
    endtask

    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            m_axis_tready <= !roll(FLOW_RX_STALLS);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (max_due.size() == 0)
            begin
                $error("window_max: expected none, actual %0d",
                       $signed(m_axis_tdata[swm_pkg::SAMPLE_BITS-1:0]));
                fails++;
            end
            else
            begin
                if (m_axis_tdata[swm_pkg::SAMPLE_BITS-1:0] !== max_due[0])
                begin
                    $error("window_max: expected %0d, actual %0d", max_due[0],
                           $signed(m_axis_tdata[swm_pkg::SAMPLE_BITS-1:0]));
                    fails++;
                end
                max_due.delete(0);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("sliding_window_maximum_core_tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        logic signed [swm_pkg::SAMPLE_BITS-1:0] last;
        bit                                     first_sos;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        last          = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_WINDOW)
            begin
                write_window(plan[i].win);
            end
            else
            begin
                send_sample(plan[i].sample, plan[i].sos, plan[i].chk, plan[i].value);
            end
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            write_window((ph < 8)
                ? swm_pkg::CFG_BITS'(window_plan[ph])
                : swm_pkg::CFG_BITS'($urandom_range(1, swm_pkg::MAX_WINDOW)));
            flow = flow_t'(ph % 4);
            first_sos = ($urandom_range(0, 9) < 3);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == PHASE_ITEMS / 2 && ph % 3 == 1)
                begin
                    // hold the stream until the pipe has delivered everything
                    s_axis_tvalid <= 1'b0;
                    while (max_due.size() != 0)
                    begin
                        @(posedge clk);
                    end
                    @(posedge clk);
                end
                last = pick_sample(last);
                send_sample(last, (n == 0) ? first_sos : ($urandom_range(0, 79) == 0),
                            CHK_MODEL, '0);
            end
        end

        s_axis_tvalid <= 1'b0;
        flow = FLOW_FREE;
        @(posedge clk);
        while (max_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
        if (fails == 0)
        begin
            $display("sliding_window_maximum_core_tb OK");
        end
        else
        begin
            $display("sliding_window_maximum_core_tb NOT OK");
        end
        $finish;
    end

endmodule
